// ===== rtl/rrjs_pkg.sv =====
// Shared types, constants and helpers of the round-robin job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rrjs_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int CPU_SLOTS_DEF   = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROC_COUNT = 2'd0;
    localparam logic [1:0] CFG_QUANTUM    = 2'd1;
    localparam logic [1:0] CFG_PENALTY    = 2'd2;
    localparam logic [1:0] CFG_MAX_BURST  = 2'd3;

    // Configuration reset values
    localparam logic [2:0]  PROC_COUNT_RST = 3'd4;
    localparam logic [15:0] QUANTUM_RST    = 16'd50;
    localparam logic [7:0]  PENALTY_RST    = 8'd10;
    localparam logic [15:0] MAX_BURST_RST  = 16'd11000;

    // Result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic arrive;
        logic disp_rd;
        logic disp_ld;
        logic serve;
        logic emit;
        logic finish;
    } rr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic disp_ok;
    } rr_stat_t;

    // One ready-queue entry
    typedef struct packed {
        logic [5:0]  job_id;
        logic [15:0] remaining;
        logic [31:0] wait_sum;
        logic [31:0] enq_tick;
    } rr_entry_t;

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rrjs_ctrl.sv =====
// Controller state machine that sequences the steps of one tick.
`timescale 1ns / 1ps
`default_nettype none
module rrjs_ctrl #(
    parameter int CPU_SLOTS = rrjs_pkg::CPU_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire rrjs_pkg::rr_stat_t             stat,
    output rrjs_pkg::rr_cmd_t                   cmd,
    output logic [$clog2(CPU_SLOTS+1)-1:0]      idx
);
    import rrjs_pkg::*;

    localparam int CW = $clog2(CPU_SLOTS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(CPU_SLOTS);
    localparam logic [CW-1:0] SRV_LAST = CW'(CPU_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP_CHK,
        ST_DISP_LD,
        ST_SERVE,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            busy_reg, busy_next;

    // Decode commands from the current step
    always_comb
    begin
        cmd         = '0;
        cmd.arrive  = (state_reg == ST_IDLE) && start;
        cmd.disp_rd = (state_reg == ST_DISP_CHK) && (idx_reg != LAST_IDX) && stat.disp_ok;
        cmd.disp_ld = (state_reg == ST_DISP_LD);
        cmd.serve   = (state_reg == ST_SERVE);
        cmd.emit    = (state_reg == ST_EMIT);
        cmd.finish  = (state_reg == ST_EMIT) && (idx_reg == LAST_IDX);
    end

    // Advance through dispatch, service and result phases
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISP_CHK;
                    idx_next   = '0;
                end
            end
            ST_DISP_CHK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_SERVE;
                    idx_next   = '0;
                end
                else if (stat.disp_ok)
                begin
                    state_next = ST_DISP_LD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_DISP_LD:
            begin
                state_next = ST_DISP_CHK;
                idx_next   = idx_reg + CW'(1);
            end
            ST_SERVE:
            begin
                if (idx_reg == SRV_LAST)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // Hold state, index and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign idx  = idx_reg;

endmodule
`default_nettype wire

// ===== rtl/rrjs_datapath.sv =====
// Datapath: ready-queue memory, processor slots, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module rrjs_datapath #(
    parameter int QUEUE_DEPTH = rrjs_pkg::QUEUE_DEPTH_DEF,
    parameter int CPU_SLOTS   = rrjs_pkg::CPU_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [15:0]                    cfg_data,
    input  wire logic                           arrival_valid,
    input  wire logic [15:0]                    burst_cycles,
    input  wire rrjs_pkg::rr_cmd_t              cmd,
    input  wire logic [$clog2(CPU_SLOTS+1)-1:0] idx,
    output rrjs_pkg::rr_stat_t                  stat,
    output logic                                result_valid,
    output logic                                status,
    output logic [5:0]                          job_id,
    output logic [31:0]                         wait_ticks,
    output logic [31:0]                         finish_tick,
    output logic [31:0]                         penalty_total,
    output logic                                last_of_tick
);
    import rrjs_pkg::*;

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW   = $clog2(CPU_SLOTS + 1);
    localparam int IW   = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
    localparam logic [PW-1:0]   PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(QUEUE_DEPTH);

    // Configuration
    logic [2:0]  proc_count_reg;
    logic [15:0] quantum_reg;
    logic [7:0]  penalty_reg;
    logic [15:0] max_burst_reg;

    // Queue control and tick state
    logic [PW-1:0]        head_reg, tail_reg;
    logic [CNTW-1:0]      count_reg;
    logic [5:0]           next_id_reg;
    logic [31:0]          tick_reg, penalty_sum_reg;
    logic                 drop_reg;
    logic [5:0]           drop_id_reg;
    logic [CPU_SLOTS-1:0] done_reg;

    // Processor slots
    logic [CPU_SLOTS-1:0] cpu_busy_reg;
    logic [5:0]           cpu_id_reg    [CPU_SLOTS];
    logic [15:0]          cpu_rem_reg   [CPU_SLOTS];
    logic [15:0]          cpu_slice_reg [CPU_SLOTS];
    logic [31:0]          cpu_wsum_reg  [CPU_SLOTS];

    // Queue memory
    rr_entry_t mem [QUEUE_DEPTH];
    rr_entry_t rd_q;
    rr_entry_t wr_data;
    logic      wr_en;

    logic [IW-1:0]  ci, ei;
    logic [CW-1:0]  idx_m1;
    logic           full;
    logic [15:0]    burst_clamp, q_eff, rem_n, slice_n;
    logic           arrive_push, srv_push;
    logic [CPU_SLOTS:0] ev;
    logic           later;

    assign ci     = idx[IW-1:0];
    assign idx_m1 = idx - CW'(1);
    assign ei     = idx_m1[IW-1:0];
    assign full   = (count_reg == CNT_FULL);

    // Clamp the arriving burst to [1, max_burst]
    always_comb
    begin
        burst_clamp = (burst_cycles > max_burst_reg) ? max_burst_reg : burst_cycles;
        if (burst_clamp == 16'd0)
        begin
            burst_clamp = 16'd1;
        end
    end

    // Service arithmetic for the slot under the index
    assign q_eff   = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign rem_n   = (cpu_rem_reg[ci] != 16'd0) ? cpu_rem_reg[ci] - 16'd1 : 16'd0;
    assign slice_n = cpu_slice_reg[ci] + 16'd1;

    assign arrive_push = cmd.arrive && arrival_valid && !full;
    assign srv_push    = cmd.serve && cpu_busy_reg[ci] && (rem_n != 16'd0)
                         && (slice_n >= q_eff) && !full;
    assign wr_en       = arrive_push || srv_push;

    // Select the entry to append
    always_comb
    begin
        if (arrive_push)
        begin
            wr_data.job_id    = next_id_reg;
            wr_data.remaining = burst_clamp;
            wr_data.wait_sum  = 32'd0;
        end
        else
        begin
            wr_data.job_id    = cpu_id_reg[ci];
            wr_data.remaining = rem_n;
            wr_data.wait_sum  = cpu_wsum_reg[ci];
        end
        wr_data.enq_tick = tick_reg;
    end

    // Dispatch check for the slot under the index
    assign stat.disp_ok = (32'(idx) < 32'(proc_count_reg)) && !cpu_busy_reg[ci]
                          && (count_reg != '0);

    // Pending results of this tick and whether any follows the index
    assign ev = {done_reg, drop_reg};
    always_comb
    begin
        later = 1'b0;
        for (int j = 0; j <= CPU_SLOTS; j++)
        begin
            if (j > int'(idx))
            begin
                later = later | ev[j];
            end
        end
    end

    // Write and read the queue memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (cmd.disp_rd)
        begin
            rd_q <= mem[head_reg];
        end
    end

    // Update configuration, queue control and processor slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_count_reg  <= PROC_COUNT_RST;
            quantum_reg     <= QUANTUM_RST;
            penalty_reg     <= PENALTY_RST;
            max_burst_reg   <= MAX_BURST_RST;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            next_id_reg     <= '0;
            tick_reg        <= '0;
            penalty_sum_reg <= '0;
            drop_reg        <= 1'b0;
            drop_id_reg     <= '0;
            done_reg        <= '0;
            cpu_busy_reg    <= '0;
            result_valid    <= 1'b0;
            for (int i = 0; i < CPU_SLOTS; i++)
            begin
                cpu_id_reg[i]    <= '0;
                cpu_rem_reg[i]   <= '0;
                cpu_slice_reg[i] <= '0;
                cpu_wsum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PROC_COUNT: proc_count_reg <= cfg_data[2:0];
                    CFG_QUANTUM:    quantum_reg    <= cfg_data;
                    CFG_PENALTY:    penalty_reg    <= cfg_data[7:0];
                    CFG_MAX_BURST:  max_burst_reg  <= cfg_data;
                    default:        ;
                endcase
            end

            // Take the arrival and open a new tick
            if (cmd.arrive)
            begin
                drop_reg    <= arrival_valid && full;
                drop_id_reg <= next_id_reg;
                done_reg    <= '0;
                if (arrival_valid)
                begin
                    next_id_reg <= next_id_reg + 6'd1;
                end
            end

            // Advance tail and count on append, head and count on dispatch
            if (wr_en)
            begin
                tail_reg  <= (tail_reg == PTR_LAST) ? '0 : tail_reg + PW'(1);
                count_reg <= count_reg + CNTW'(1);
            end
            else if (cmd.disp_ld)
            begin
                head_reg  <= (head_reg == PTR_LAST) ? '0 : head_reg + PW'(1);
                count_reg <= count_reg - CNTW'(1);
            end

            // Load the head job into the slot
            if (cmd.disp_ld)
            begin
                cpu_busy_reg[ci]  <= 1'b1;
                cpu_id_reg[ci]    <= rd_q.job_id;
                cpu_rem_reg[ci]   <= rd_q.remaining;
                cpu_slice_reg[ci] <= '0;
                cpu_wsum_reg[ci]  <= sat_add32(rd_q.wait_sum, tick_reg - rd_q.enq_tick);
                penalty_sum_reg   <= sat_add32(penalty_sum_reg, {24'd0, penalty_reg});
            end

            // Serve one tick on the slot
            if (cmd.serve && cpu_busy_reg[ci])
            begin
                cpu_rem_reg[ci]   <= rem_n;
                cpu_slice_reg[ci] <= slice_n;
                if (rem_n == 16'd0)
                begin
                    cpu_busy_reg[ci] <= 1'b0;
                    done_reg[ci]     <= 1'b1;
                end
                else if (slice_n >= q_eff)
                begin
                    if (full)
                    begin
                        cpu_slice_reg[ci] <= '0;
                    end
                    else
                    begin
                        cpu_busy_reg[ci] <= 1'b0;
                    end
                end
            end

            // Strobe a result for a pending event
            result_valid <= cmd.emit && ev[idx];

            if (cmd.finish)
            begin
                tick_reg <= tick_reg + 32'd1;
            end
        end
    end

    // Fill the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            finish_tick   <= tick_reg;
            penalty_total <= penalty_sum_reg;
            last_of_tick  <= !later;
            if (idx == '0)
            begin
                status     <= STATUS_DROP;
                job_id     <= drop_id_reg;
                wait_ticks <= 32'd0;
            end
            else
            begin
                status     <= STATUS_DONE;
                job_id     <= cpu_id_reg[ei];
                wait_ticks <= cpu_wsum_reg[ei];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("ready count exceeds queue depth");

    a_ld_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.disp_ld |-> $past(cmd.disp_rd))
        else $error("dispatch load without a memory read");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_FULL) |-> head_reg == tail_reg)
        else $error("queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.disp_rd |-> count_reg != '0)
        else $error("dispatch from an empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/round_robin_job_scheduler_top.sv =====
// Top level of the round-robin job scheduler.
//
// One item is one scheduler tick. Pulse start while busy is low, with
// arrival_valid and burst_cycles giving an optional arriving job; the item is
// taken at that edge. busy then stays high until the tick is finished.
// Within a tick the controller walks the processor slots for dispatch, with
// an extra step for each job pulled from the queue memory, then walks the
// slots for service, then each result position (the drop slot plus every
// processor). Results leave on result_valid, at most one per cycle, during the
// result phase; a drop comes first, then completions in processor order, and
// last_of_tick marks the final one. A tick with no event gives no strobe. The
// receiver cannot stall: each result is present for exactly one cycle.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset empties the queue, idles all processors and loads default settings.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_job_scheduler_top #(
    parameter int QUEUE_DEPTH = rrjs_pkg::QUEUE_DEPTH_DEF,
    parameter int CPU_SLOTS   = rrjs_pkg::CPU_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        arrival_valid,
    input  wire logic [15:0] burst_cycles,
    output logic             result_valid,
    output logic             status,
    output logic [5:0]       job_id,
    output logic [31:0]      wait_ticks,
    output logic [31:0]      finish_tick,
    output logic [31:0]      penalty_total,
    output logic             last_of_tick
);
    import rrjs_pkg::*;

    localparam int CW = $clog2(CPU_SLOTS + 1);

    rr_cmd_t       cmd;
    rr_stat_t      stat;
    logic [CW-1:0] idx;

    rrjs_ctrl #(
        .CPU_SLOTS (CPU_SLOTS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd),
        .idx   (idx)
    );

    rrjs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CPU_SLOTS   (CPU_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .arrival_valid (arrival_valid),
        .burst_cycles  (burst_cycles),
        .cmd           (cmd),
        .idx           (idx),
        .stat          (stat),
        .result_valid  (result_valid),
        .status        (status),
        .job_id        (job_id),
        .wait_ticks    (wait_ticks),
        .finish_tick   (finish_tick),
        .penalty_total (penalty_total),
        .last_of_tick  (last_of_tick)
    );

endmodule
`default_nettype wire

// ===== bench/tb_checker.sv =====
// Scheduler predictor and result checker for the round-robin job scheduler bench.
`timescale 1ns / 1ps
`default_nettype none
module tb_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        arrival_valid,
    input  wire logic [15:0] burst_cycles,
    input  wire logic        result_valid,
    input  wire logic        status,
    input  wire logic [5:0]  job_id,
    input  wire logic [31:0] wait_ticks,
    input  wire logic [31:0] finish_tick,
    input  wire logic [31:0] penalty_total,
    input  wire logic        last_of_tick,
    output int               fail_count,
    output int               pending_count
);
    import rrjs_pkg::*;

    localparam int QD = 64;
    localparam int NCPU = 4;

    typedef struct packed {
        logic        status;
        logic [5:0]  job_id;
        logic [31:0] wait_ticks;
        logic [31:0] finish_tick;
        logic [31:0] penalty_total;
        logic        last_of_tick;
    } sched_event_t;

    sched_event_t expected_events[$];

    // Scheduler settings and state
    logic [2:0]  set_procs;
    logic [15:0] set_quantum;
    logic [7:0]  set_penalty;
    logic [15:0] set_max_burst;
    rr_entry_t   ready_q[QD];
    int          q_head, q_tail, q_count;
    logic        cpu_on[NCPU];
    logic [5:0]  cpu_id[NCPU];
    logic [15:0] cpu_left[NCPU];
    logic [16:0] cpu_used[NCPU];
    logic [31:0] cpu_wait[NCPU];
    logic [5:0]  next_id;
    logic [31:0] tick_now;
    logic [31:0] penalty_acc;

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic push_ready(input logic [5:0] id, input logic [15:0] left,
                                        input logic [31:0] wsum);
        if (q_count >= QD) return 1'b0;
        ready_q[q_tail] = '{job_id: id, remaining: left, wait_sum: wsum, enq_tick: tick_now};
        q_tail = (q_tail + 1) % QD;
        q_count++;
        return 1'b1;
    endfunction

    // Advance the scheduler by one tick and queue the events it reports
    task automatic run_tick(input logic arrive, input logic [15:0] burst);
        sched_event_t evs[$];
        sched_event_t ev;
        logic [15:0] b;
        int active;
        logic [16:0] quantum;
        rr_entry_t h;
        if (arrive)
        begin
            b = burst > set_max_burst ? set_max_burst : burst;
            if (b == 16'd0) b = 16'd1;
            if (!push_ready(next_id, b, 32'd0))
            begin
                ev = '0;
                ev.status = STATUS_DROP;
                ev.job_id = next_id;
                evs.insert(evs.size(), ev);
            end
            next_id = next_id + 6'd1;
        end
        active = set_procs > NCPU ? NCPU : set_procs;
        for (int i = 0; i < active; i++)
        begin
            if (!cpu_on[i] && q_count > 0)
            begin
                h = ready_q[q_head];
                cpu_on[i] = 1'b1;
                cpu_id[i] = h.job_id;
                cpu_left[i] = h.remaining;
                cpu_used[i] = '0;
                cpu_wait[i] = add_sat(h.wait_sum, tick_now - h.enq_tick);
                q_head = (q_head + 1) % QD;
                q_count--;
                penalty_acc = add_sat(penalty_acc, {24'd0, set_penalty});
            end
        end
        quantum = set_quantum == 16'd0 ? 17'd1 : {1'b0, set_quantum};
        for (int i = 0; i < NCPU; i++)
        begin
            if (!cpu_on[i]) continue;
            if (cpu_left[i] > 0) cpu_left[i]--;
            cpu_used[i]++;
            if (cpu_left[i] == 16'd0)
            begin
                cpu_on[i] = 1'b0;
                ev = '0;
                ev.status = STATUS_DONE;
                ev.job_id = cpu_id[i];
                ev.wait_ticks = cpu_wait[i];
                evs.insert(evs.size(), ev);
            end
            else if (cpu_used[i] >= quantum)
            begin
                if (push_ready(cpu_id[i], cpu_left[i], cpu_wait[i])) cpu_on[i] = 1'b0;
                else cpu_used[i] = '0;
            end
        end
        foreach (evs[k])
        begin
            evs[k].finish_tick = tick_now;
            evs[k].penalty_total = penalty_acc;
            evs[k].last_of_tick = (k == evs.size() - 1);
            expected_events.insert(expected_events.size(), evs[k]);
        end
        tick_now = tick_now + 32'd1;
    endtask

    // Track configuration, accept items and compare results
    always @(posedge clk or negedge rst_n)
    begin
        sched_event_t got, want;
        if (!rst_n)
        begin
            set_procs = PROC_COUNT_RST;
            set_quantum = QUANTUM_RST;
            set_penalty = PENALTY_RST;
            set_max_burst = MAX_BURST_RST;
            q_head = 0; q_tail = 0; q_count = 0;
            for (int i = 0; i < NCPU; i++)
            begin
                cpu_on[i] = 1'b0; cpu_id[i] = '0; cpu_left[i] = '0; cpu_used[i] = '0;
                cpu_wait[i] = '0;
            end
            next_id = '0; tick_now = '0; penalty_acc = '0;
            expected_events.delete();
            fail_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                got = '{status, job_id, wait_ticks, finish_tick, penalty_total, last_of_tick};
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %p", got);
                end
                else
                begin
                    want = expected_events[0];
                    expected_events.delete(0);
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PROC_COUNT: set_procs = cfg_data[2:0];
                    CFG_QUANTUM:    set_quantum = cfg_data;
                    CFG_PENALTY:    set_penalty = cfg_data[7:0];
                    CFG_MAX_BURST:  set_max_burst = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                run_tick(arrival_valid, burst_cycles);
        end
        pending_count = expected_events.size();
    end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the round-robin job scheduler bench.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import rrjs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_PROC_COUNT;
    logic [15:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        arrival_valid = 1'b0;
    logic [15:0] burst_cycles = '0;
    wire logic   busy, result_valid, status, last_of_tick;
    wire logic [5:0]  job_id;
    wire logic [31:0] wait_ticks, finish_tick, penalty_total;
    int fail_count, pending_count;
    int idle_pct;

    always #1 clk = ~clk;

    round_robin_job_scheduler_top dut (.*);
    tb_checker checker_i (.*);

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Let every expected result drain, then pad for a tick with no results
    task automatic settle();
        while (pending_count != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Offer one tick; hold start until the block takes it
    task automatic send_tick(input logic arrive, input logic [15:0] burst);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) @(negedge clk);
        start = 1'b1; arrival_valid = arrive; burst_cycles = burst;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        arrival_valid = 1'($urandom_range(1, 0));
        burst_cycles = 16'($urandom);
    endtask

    task automatic random_phase(input int n, input int pct, input int burst_hi);
        idle_pct = pct;
        repeat (n)
            send_tick($urandom_range(99, 0) < 60, ($urandom_range(9, 0) == 0) ?
                      16'($urandom) : 16'($urandom_range(burst_hi, 0)));
        idle_pct = 0;
        settle();
    endtask

    initial
    begin
        idle_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes of burst, zero burst, clamp, empty ticks
        send_tick(1'b1, 16'd0);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b1, 16'd1);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'h5555);
        send_tick(1'b1, 16'hAAAA);
        settle();
        write_reg(CFG_MAX_BURST, 16'd0);
        write_reg(CFG_QUANTUM, 16'd0);
        write_reg(CFG_PENALTY, 16'd255);
        write_reg(CFG_PROC_COUNT, 16'd7);
        repeat (4) send_tick(1'b1, 16'hFFFF);
        settle();
        // No processors: fill the queue until arrivals drop
        write_reg(CFG_PROC_COUNT, 16'd0);
        write_reg(CFG_MAX_BURST, 16'd3);
        repeat (66) send_tick(1'b1, 16'($urandom));
        settle();
        write_reg(CFG_PROC_COUNT, 16'd1);
        write_reg(CFG_QUANTUM, 16'd1);
        repeat (8) send_tick(1'b1, 16'd2);
        // Pause until every expected result has come
        settle();
        repeat (20) send_tick(1'b0, 16'd0);
        settle();

        // Random phases across settings and idling
        write_reg(CFG_PROC_COUNT, 16'd4);
        write_reg(CFG_QUANTUM, 16'd3);
        write_reg(CFG_PENALTY, 16'd0);
        write_reg(CFG_MAX_BURST, 16'd12);
        random_phase(20, 0, 20);
        write_reg(CFG_PROC_COUNT, 16'd2);
        write_reg(CFG_QUANTUM, 16'd2);
        write_reg(CFG_PENALTY, 16'd200);
        random_phase(20, 87, 8);
        write_reg(CFG_PROC_COUNT, 16'd3);
        write_reg(CFG_QUANTUM, 16'hFFFF);
        write_reg(CFG_MAX_BURST, 16'd6);
        random_phase(20, 32, 10);
        write_reg(CFG_PROC_COUNT, 16'd1);
        write_reg(CFG_QUANTUM, 16'd1);
        write_reg(CFG_MAX_BURST, 16'hFFFF);
        random_phase(15, 0, 6);
        // Run a few empty ticks with every processor
        write_reg(CFG_PROC_COUNT, 16'd4);
        repeat (5) send_tick(1'b0, 16'd0);
        settle();

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire
